FILE: hdl/cia_pkg.sv
package cia_pkg;

  localparam int unsigned RES_W  = 33;
  localparam int unsigned KIND_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_EQ  = 3'd4
  } kind_e;

  // one-hot operation class; all zero for codes with no meaning
  typedef struct packed {
    logic add;
    logic sub;
    logic mul;
    logic div;
    logic eq;
  } op_cls_t;

  // sideband that travels alongside the divider
  typedef struct packed {
    logic [RES_W-1:0] dre;
    logic [RES_W-1:0] dim;
    op_cls_t          cls;
    logic             eq;
    logic             dz;
    logic             neg_re;
    logic             neg_im;
  } side_t;

endpackage

FILE: hdl/cia_if.sv
interface cia_in_if #(
  parameter int unsigned W = 16
);
  logic                valid;
  logic                ready;
  logic [2:0]          kind;
  logic signed [W-1:0] a_re;
  logic signed [W-1:0] a_im;
  logic signed [W-1:0] b_re;
  logic signed [W-1:0] b_im;

  modport source (output valid, kind, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, kind, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cia_out_if;
  logic               valid;
  logic               ready;
  logic signed [32:0] res_re;
  logic signed [32:0] res_im;
  logic               is_equal;
  logic               divide_by_zero;

  modport source (output valid, res_re, res_im, is_equal, divide_by_zero, input ready);
  modport sink   (input valid, res_re, res_im, is_equal, divide_by_zero, output ready);
endinterface

FILE: hdl/cia_front.sv
module cia_front #(
  parameter int unsigned W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  cia_in_if.sink           in_i,
  output logic             valid_o,
  input  logic             ready_i,
  output cia_pkg::op_cls_t cls_o,
  output logic [4*W-1:0]   opnd_o
);
  import cia_pkg::*;

  logic     valid_q;
  op_cls_t  cls_d, cls_q;
  logic [4*W-1:0] opnd_q;
  logic     take;

  assign in_i.ready = !valid_q || ready_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    cls_d = '0;
    unique case (in_i.kind)
      KIND_ADD: cls_d.add = 1'b1;
      KIND_SUB: cls_d.sub = 1'b1;
      KIND_MUL: cls_d.mul = 1'b1;
      KIND_DIV: cls_d.div = 1'b1;
      KIND_EQ:  cls_d.eq  = 1'b1;
      default:  cls_d     = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cls_q  <= cls_d;
      opnd_q <= {in_i.a_re, in_i.a_im, in_i.b_re, in_i.b_im};
    end
  end

  assign valid_o = valid_q;
  assign cls_o   = cls_q;
  assign opnd_o  = opnd_q;

endmodule

FILE: hdl/cia_queue.sv
module cia_queue #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  logic [DW-1:0] wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output logic [DW-1:0] rd_data_o
);
  logic [DW-1:0] mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("full queue with pointers apart");

endmodule

FILE: hdl/cia_back.sv
module cia_back #(
  parameter int unsigned W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  cia_pkg::op_cls_t cls_i,
  input  logic [4*W-1:0]   opnd_i,
  cia_out_if.source        out_o
);
  import cia_pkg::*;

  localparam int unsigned PW = 2 * W;        // product width
  localparam int unsigned MW = 2 * W + 1;    // numerator width, quotient bits
  localparam int unsigned DW = 2 * W;        // denominator / remainder width
  localparam int unsigned SW = (2 * W + 2 > RES_W + 1) ? 2 * W + 2 : RES_W + 1;
  localparam int unsigned QW = (MW > RES_W) ? MW : RES_W;

  logic en;
  assign en      = !out_o.valid || out_o.ready;
  assign ready_o = en;

  // stage 1: operands
  logic v1_q;
  op_cls_t cls1_q;
  logic signed [W-1:0] ar_q, ai_q, br_q, bi_q;

  // stage 2: products and short sums
  logic v2_q;
  op_cls_t cls2_q;
  logic eq2_q;
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [W:0]    sre_q, sim_q;

  // stage 3: numerators, denominator, direct results
  logic v3_q;
  side_t side3_q;
  logic signed [MW-1:0] nre_q, nim_q;
  logic [DW-1:0]        den3_q;

  // divider chain, entry 0 is loaded with magnitudes
  logic          vd_q   [MW+1];
  side_t         sided_q[MW+1];
  logic [DW-1:0] dend_q [MW+1];
  logic [DW-1:0] remr_q [MW+1];
  logic [DW-1:0] remi_q [MW+1];
  logic [MW-1:0] nqr_q  [MW+1];
  logic [MW-1:0] nqi_q  [MW+1];

  logic out_v_q;
  logic signed [RES_W-1:0] ore_q, oim_q;
  logic oeq_q, odz_q;

  // stage 3 combinational
  logic signed [SW-1:0] mre, mim, are, aim;
  side_t side3_d;
  side_t side4_d;

  always_comb begin
    mre = SW'(p0_q) - SW'(p2_q);
    mim = SW'(p1_q) + SW'(p3_q);
    are = SW'(sre_q);
    aim = SW'(sim_q);
    side3_d     = '0;
    side3_d.cls = cls2_q;
    side3_d.eq  = eq2_q && cls2_q.eq;
    if (cls2_q.add || cls2_q.sub) begin
      side3_d.dre = are[RES_W-1:0];
      side3_d.dim = aim[RES_W-1:0];
    end else if (cls2_q.mul) begin
      side3_d.dre = mre[RES_W-1:0];
      side3_d.dim = mim[RES_W-1:0];
    end
  end

  always_comb begin
    side4_d        = side3_q;
    side4_d.dz     = side3_q.cls.div && (den3_q == '0);
    side4_d.neg_re = nre_q[MW-1];
    side4_d.neg_im = nim_q[MW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      vd_q[0] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      vd_q[0] <= v3_q;
      out_v_q <= vd_q[MW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cls1_q <= cls_i;
      {ar_q, ai_q, br_q, bi_q} <= opnd_i;

      cls2_q <= cls1_q;
      eq2_q  <= (ar_q == br_q) && (ai_q == bi_q);
      p0_q   <= ar_q * br_q;
      p1_q   <= ar_q * bi_q;
      p2_q   <= ai_q * bi_q;
      p3_q   <= ai_q * br_q;
      p4_q   <= br_q * br_q;
      p5_q   <= bi_q * bi_q;
      sre_q  <= cls1_q.sub ? (W+1)'(ar_q) - (W+1)'(br_q) : (W+1)'(ar_q) + (W+1)'(br_q);
      sim_q  <= cls1_q.sub ? (W+1)'(ai_q) - (W+1)'(bi_q) : (W+1)'(ai_q) + (W+1)'(bi_q);

      side3_q <= side3_d;
      // re = ar*br + ai*bi, im = ai*br - ar*bi
      nre_q   <= MW'(p0_q) + MW'(p2_q);
      nim_q   <= MW'(p3_q) - MW'(p1_q);
      den3_q  <= p4_q[DW-1:0] + p5_q[DW-1:0];

      sided_q[0] <= side4_d;
      dend_q[0] <= den3_q;
      remr_q[0] <= '0;
      remi_q[0] <= '0;
      nqr_q[0]  <= nre_q[MW-1] ? MW'(-nre_q) : MW'(nre_q);
      nqi_q[0]  <= nim_q[MW-1] ? MW'(-nim_q) : MW'(nim_q);
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < MW; k++) begin : g_div
    logic [DW:0] tr, ti;
    logic        ger, gei;

    assign tr  = {remr_q[k], nqr_q[k][MW-1]};
    assign ti  = {remi_q[k], nqi_q[k][MW-1]};
    assign ger = tr >= {1'b0, dend_q[k]};
    assign gei = ti >= {1'b0, dend_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[k+1] <= 1'b0;
      end else if (en) begin
        vd_q[k+1] <= vd_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sided_q[k+1] <= sided_q[k];
        dend_q[k+1]  <= dend_q[k];
        remr_q[k+1]  <= ger ? DW'(tr - {1'b0, dend_q[k]}) : tr[DW-1:0];
        remi_q[k+1]  <= gei ? DW'(ti - {1'b0, dend_q[k]}) : ti[DW-1:0];
        nqr_q[k+1]   <= {nqr_q[k][MW-2:0], ger};
        nqi_q[k+1]   <= {nqi_q[k][MW-2:0], gei};
      end
    end
  end

  // output stage
  side_t sf;
  logic [QW-1:0] qre, qim, fre, fim;

  always_comb begin
    sf  = sided_q[MW];
    qre = QW'(nqr_q[MW]);
    qim = QW'(nqi_q[MW]);
    fre = sf.neg_re ? QW'(-qre) : qre;
    fim = sf.neg_im ? QW'(-qim) : qim;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oeq_q <= sf.eq;
      odz_q <= sf.dz;
      if (sf.cls.div && !sf.dz) begin
        ore_q <= fre[RES_W-1:0];
        oim_q <= fim[RES_W-1:0];
      end else if (sf.cls.div) begin
        ore_q <= '0;
        oim_q <= '0;
      end else begin
        ore_q <= sf.dre;
        oim_q <= sf.dim;
      end
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.res_re         = ore_q;
  assign out_o.res_im         = oim_q;
  assign out_o.is_equal       = oeq_q;
  assign out_o.divide_by_zero = odz_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> $onehot0(cls1_q))
    else $error("operation class not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && odz_q) |-> (ore_q == '0 && oim_q == '0 && !oeq_q))
    else $error("divide by zero with non-zero result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && oeq_q) |-> (ore_q == '0 && oim_q == '0))
    else $error("equality test with non-zero result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vd_q[0]) && $stable(out_v_q))
    else $error("pipeline moved while stalled");

endmodule

FILE: hdl/complex_integer_alu.sv
// Complex integer ALU.
// in_i carries kind and two complex operands a and b (OPERAND_WIDTH-bit
// signed parts); out_o returns res_re/res_im (33-bit signed), is_equal and
// divide_by_zero. One result item per input item, in order.
// kind: add, subtract, multiply, divide (a*conj(b)/|b|^2, truncated toward
// zero), equality test. Unused codes give an all-zero result.
// From acceptance to out_o.valid an item passes the front register, the
// queue, four arithmetic stages, one restoring divider stage per quotient
// bit (2*OPERAND_WIDTH+1), then the output register. Every kind takes the
// same path, so order holds.
// Throughput is one item per cycle while out_o.ready stays high.
// When the receiver stalls, the back pipeline freezes, the two-entry queue
// fills and the front register holds one more item before in_i.ready drops.
// Reset clears all valid flags and queue pointers; no results are pending
// afterwards and in_i.ready is high as soon as reset is released.
module complex_integer_alu #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cia_in_if.sink    in_i,
  cia_out_if.source out_o
);
  import cia_pkg::*;

  localparam int unsigned OW = 4 * OPERAND_WIDTH;
  localparam int unsigned QD = OW + $bits(op_cls_t);

  logic          f_valid, f_ready;
  op_cls_t       f_cls, b_cls;
  logic [OW-1:0] f_opnd, b_opnd;
  logic          b_valid, b_ready;

  cia_front #(.W(OPERAND_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (f_valid),
    .ready_i (f_ready),
    .cls_o   (f_cls),
    .opnd_o  (f_opnd)
  );

  cia_queue #(.DW(QD)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  ({f_cls, f_opnd}),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  ({b_cls, b_opnd})
  );

  cia_back #(.W(OPERAND_WIDTH)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_valid),
    .ready_o (b_ready),
    .cls_i   (b_cls),
    .opnd_i  (b_opnd),
    .out_o   (out_o)
  );

endmodule

FILE: dv/cia_checker.sv
module cia_checker (
  input  logic      clk_i,
  input  logic      rst_ni,
  cia_in_if.sink    in_i,
  cia_out_if.sink   out_o,
  output int        fail_cnt_o,
  output int        pending_o,
  output int        seen_o
);
  import cia_pkg::*;

  typedef struct {
    logic [32:0] re;
    logic [32:0] im;
    logic        eq;
    logic        dz;
  } cia_res_t;

  cia_res_t result_q[$];
  int       fails;
  int       seen;

  function automatic logic [32:0] trunc_div(longint num, longint den);
    longint q;
    q = num / den;  // SV division truncates toward zero
    return q[32:0];
  endfunction

  function automatic cia_res_t compute_result(logic [2:0] kind, logic signed [15:0] ar,
                                              logic signed [15:0] ai, logic signed [15:0] br,
                                              logic signed [15:0] bi);
    cia_res_t r;
    longint   xr, xi, yr, yi, den, t;
    xr = ar; xi = ai; yr = br; yi = bi;
    r = '{default: '0};
    case (kind)
      KIND_ADD: begin
        t = xr + yr; r.re = t[32:0];
        t = xi + yi; r.im = t[32:0];
      end
      KIND_SUB: begin
        t = xr - yr; r.re = t[32:0];
        t = xi - yi; r.im = t[32:0];
      end
      KIND_MUL: begin
        t = xr * yr - xi * yi; r.re = t[32:0];
        t = xr * yi + xi * yr; r.im = t[32:0];
      end
      KIND_DIV: begin
        den = yr * yr + yi * yi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          r.re = trunc_div(xr * yr + xi * yi, den);
          r.im = trunc_div(xi * yr - xr * yi, den);
        end
      end
      KIND_EQ: r.eq = (ar == br) && (ai == bi);
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    cia_res_t e;
    if (rst_ni) begin
      if (in_i.valid && in_i.ready)
        result_q.push_back(compute_result(in_i.kind, in_i.a_re, in_i.a_im, in_i.b_re,
                                          in_i.b_im));
      if (out_o.valid && out_o.ready) begin
        seen++;
        if (result_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result item re=%h im=%h", out_o.res_re,
                                    out_o.res_im);
        end else begin
          e = result_q.pop_front();
          if (out_o.res_re !== e.re || out_o.res_im !== e.im ||
              out_o.is_equal !== e.eq || out_o.divide_by_zero !== e.dz) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp re=%h im=%h eq=%b dz=%b got re=%h im=%h eq=%b dz=%b",
                       e.re, e.im, e.eq, e.dz, out_o.res_re, out_o.res_im,
                       out_o.is_equal, out_o.divide_by_zero);
          end
        end
      end
    end
  end

  initial begin
    fails = 0;
    seen  = 0;
  end

  assign fail_cnt_o = fails + result_q.size();
  assign pending_o  = result_q.size();
  assign seen_o     = seen;
endmodule

FILE: dv/complex_integer_alu_tb.sv
module complex_integer_alu_tb;
  import cia_pkg::*;

  localparam int LATENCY = 42;
  localparam int N_ITEMS = 650;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt, pending, seen;
  longint cycles = 0;
  logic hold_long = 1'b0;
  int   sent = 0;

  cia_in_if  #(.W(16)) in_if ();
  cia_out_if           out_if ();

  complex_integer_alu dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if.sink),
                           .out_o(out_if.source));

  cia_checker u_checker (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if.sink),
                         .out_o(out_if.sink), .fail_cnt_o(fail_cnt), .pending_o(pending),
                         .seen_o(seen));

  always #4 clk_i = ~clk_i;

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'($urandom_range(0, 6)) - 16'd3;
      default: return 16'($urandom);
    endcase
  endfunction

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int g;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        out_if.ready <= 1'b0;
        for (int i = 0; i < 150; i++) @(posedge clk_i);
        hold_long = 1'b0;
      end
      g = gap_len();
      if (g == 0 || $urandom_range(0, 3) != 0) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        repeat (g - 1) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(logic [2:0] kind, logic [15:0] ar, logic [15:0] ai,
                           logic [15:0] br, logic [15:0] bi, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.kind  <= kind;
    in_if.a_re  <= ar;
    in_if.a_im  <= ai;
    in_if.b_re  <= br;
    in_if.b_im  <= bi;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent++;
  endtask

  initial begin
    logic [15:0] ext[4];
    logic [15:0] x;
    ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    in_if.valid = 1'b0;
    in_if.kind  = '0;
    in_if.a_re  = '0;
    in_if.a_im  = '0;
    in_if.b_re  = '0;
    in_if.b_im  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every code at the extremes, zero divisor, equal and unequal operands
    for (int k = 0; k < 8; k++)
      send_item(3'(k), ext[k % 4], ext[(k + 1) % 4], ext[(k + 2) % 4], ext[(k + 3) % 4], 0);
    send_item(KIND_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
    send_item(KIND_MUL, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0);
    send_item(KIND_DIV, 16'h0005, 16'h0007, 16'h0000, 16'h0000, 0);
    send_item(KIND_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000, 0);
    send_item(KIND_DIV, 16'h8000, 16'h8000, 16'hffff, 16'hffff, 0);
    send_item(KIND_DIV, 16'hfff9, 16'h0007, 16'h0002, 16'h0001, 0);
    send_item(KIND_EQ, 16'h1234, 16'h8000, 16'h1234, 16'h8000, 0);
    send_item(KIND_EQ, 16'h1234, 16'h8000, 16'h1234, 16'h8001, 0);
    send_item(KIND_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
    send_item(KIND_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0);

    // long receiver hold-off while the sender keeps pushing; more items than
    // the pipeline and queue can hold, so the input stalls
    hold_long = 1'b1;
    for (int i = 0; i < 80; i++)
      send_item(3'($urandom_range(0, 4)), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 0);

    // pause until everything has drained
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    while (sent < N_ITEMS) begin
      x = pick_operand();
      send_item($urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4)),
                pick_operand(), pick_operand(),
                $urandom_range(0, 3) == 0 ? x : pick_operand(),
                $urandom_range(0, 9) == 0 ? 16'h0000 : pick_operand(), 1);
      if ($urandom_range(0, 7) == 0) begin
        send_item(KIND_EQ, x, x, x, x, 1);
        send_item(KIND_DIV, pick_operand(), pick_operand(), 16'h0000, 16'h0000, 1);
      end
    end
    in_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("%0d items sent and %0d results checked over all codes, incl. stalls", sent,
             seen);
    $display("operand extremes, zero divisors and equal operands were included");
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
